// File: rtl/ipfm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipfm_pkg
// Shared types, constants and the netmask helper for the IPv4 prefix table.
// ----------------------------------------------------------------------------
package ipfm_pkg;

    localparam int TABLE_ENTRIES_DEFAULT = 128;
    localparam int ADDR_W                = 32;
    localparam int PREFIX_W              = 6;
    localparam int STATUS_W              = 2;
    localparam int INDEX_W               = 7;

    localparam logic [PREFIX_W-1:0] PREFIX_FULL = PREFIX_W'(32);

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT    = 2'd0,
        ST_MISS   = 2'd1,
        ST_STORED = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPEND,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   network;
        logic [PREFIX_W-1:0] prefix;
    } entry_t;

    // len is already saturated to 0..32
    function automatic logic [ADDR_W-1:0] mask_of(input logic [PREFIX_W-1:0] len);
        logic [PREFIX_W-1:0] shift;
        shift = PREFIX_FULL - len;
        if (len == '0)
        begin
            return '0;
        end
        return {ADDR_W{1'b1}} << shift;
    endfunction

endpackage
`default_nettype wire

// File: rtl/ipfm_item_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipfm_item_if
// Input channel: append or lookup request word.
// ----------------------------------------------------------------------------
interface ipfm_item_if
    import ipfm_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [ADDR_W-1:0]   address;
    logic [PREFIX_W-1:0] prefix_length;

    modport source (output valid, output kind, output address, output prefix_length,
                    input ready);
    modport sink   (input valid, input kind, input address, input prefix_length,
                    output ready);
endinterface
`default_nettype wire

// File: rtl/ipfm_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipfm_result_if
// Output channel: status and entry index word.
// ----------------------------------------------------------------------------
interface ipfm_result_if
    import ipfm_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  entry_index;

    modport source (output valid, output status, output entry_index, input ready);
    modport sink   (input valid, input status, input entry_index, output ready);
endinterface
`default_nettype wire

// File: rtl/ipv4_prefix_first_match_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_prefix_first_match_table
// IPv4 prefix table with first-match lookup in load order.
// ----------------------------------------------------------------------------
// One word at a time. An append passes through accept, store and finish on
// its way to the result register. A lookup walks the stored entries in load
// order through the single registered read port of the entry RAM and the
// one shared mask-and-compare unit, one entry per cycle. The input is ready
// only while the sequencer is idle; a finished result sits in the output
// register and the next word is taken while it waits. Entries are never
// cleared: only slots below the fill count are read, so there is no start-up
// sweep.
// ----------------------------------------------------------------------------
module ipv4_prefix_first_match_table
    import ipfm_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    ipfm_item_if.sink     item,
    ipfm_result_if.source result
);

    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int CW    = $clog2(TABLE_ENTRIES + 1);
    localparam int EXT_W = (AW > INDEX_W) ? AW : INDEX_W;

    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    state_t              state_reg, state_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [CW-1:0]       scan_reg, scan_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic                out_valid_reg, out_valid_next;

    logic [AW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [ADDR_W-1:0]   address_reg, address_next;
    logic [PREFIX_W-1:0] prefix_reg, prefix_next;
    status_t             res_status_reg, res_status_next;
    logic [AW-1:0]       res_idx_reg, res_idx_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [INDEX_W-1:0]  out_idx_reg, out_idx_next;

    logic                accept;
    logic                out_free;
    logic [PREFIX_W-1:0] prefix_sat;
    logic [EXT_W-1:0]    res_idx_ext;

    logic                ram_wr_en;
    entry_t              ram_wr_data;
    logic                ram_rd_en;
    entry_t              ram_rd_data;
    logic                match;

    ipfm_entry_ram #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (scan_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    ipfm_matcher u_match (
        .address (address_reg),
        .entry   (ram_rd_data),
        .match   (match)
    );

    assign accept      = item.valid && item.ready;
    assign out_free    = !out_valid_reg || result.ready;
    assign prefix_sat  = (item.prefix_length > PREFIX_FULL) ? PREFIX_FULL : item.prefix_length;
    assign res_idx_ext = EXT_W'(res_idx_reg);

    assign result.valid       = out_valid_reg;
    assign result.status      = out_status_reg;
    assign result.entry_index = out_idx_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = item.kind ? S_SCAN : S_APPEND;
                end
            end
            S_APPEND:
            begin
                state_next = S_FINISH;
            end
            S_SCAN:
            begin
                if ((cmp_valid_reg && match) || (scan_reg == fill_reg))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        item.ready      = 1'b0;
        fill_next       = fill_reg;
        scan_next       = scan_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        address_next    = address_reg;
        prefix_next     = prefix_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_status_next = out_status_reg;
        out_idx_next    = out_idx_reg;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        ram_wr_data.network = address_reg & mask_of(prefix_reg);
        ram_wr_data.prefix  = prefix_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                item.ready = 1'b1;
                if (accept)
                begin
                    address_next   = item.address;
                    prefix_next    = prefix_sat;
                    scan_next      = '0;
                    cmp_valid_next = 1'b0;
                end
            end
            S_APPEND:
            begin
                if (fill_reg < FULL_COUNT)
                begin
                    ram_wr_en       = 1'b1;
                    res_status_next = ST_STORED;
                    res_idx_next    = fill_reg[AW-1:0];
                    fill_next       = fill_reg + CW'(1);
                end
                else
                begin
                    res_status_next = ST_FULL;
                    res_idx_next    = '0;
                end
            end
            S_SCAN:
            begin
                cmp_valid_next = 1'b0;
                if (cmp_valid_reg && match)
                begin
                    res_status_next = ST_HIT;
                    res_idx_next    = cmp_idx_reg;
                end
                else if (scan_reg == fill_reg)
                begin
                    // every loaded slot compared without a hit
                    res_status_next = ST_MISS;
                    res_idx_next    = '0;
                end
                else
                begin
                    ram_rd_en      = 1'b1;
                    scan_next      = scan_reg + CW'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_reg[AW-1:0];
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_idx_next    = res_idx_ext[INDEX_W-1:0];
                end
            end
            default:
            begin
                item.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            scan_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            scan_reg      <= scan_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg    <= cmp_idx_next;
        address_reg    <= address_next;
        prefix_reg     <= prefix_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        out_status_reg <= out_status_next;
        out_idx_reg    <= out_idx_next;
    end

endmodule
`default_nettype wire

// File: rtl/ipfm_entry_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipfm_entry_ram
// Prefix entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ipfm_entry_ram
    import ipfm_pkg::*;
#(
    parameter int DEPTH = TABLE_ENTRIES_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/ipfm_matcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipfm_matcher
// Shared compare unit: address under the entry's mask against its network.
// ----------------------------------------------------------------------------
module ipfm_matcher
    import ipfm_pkg::*;
(
    input  logic [ADDR_W-1:0] address,
    input  entry_t            entry,
    output logic              match
);

    logic [ADDR_W-1:0] mask;

    always_comb
    begin
        mask  = mask_of(entry.prefix);
        match = ((address & mask) == entry.network);
    end

endmodule
`default_nettype wire
